/* sv/dcrb_pkg.sv */
// ============================================================================
// dcrb_pkg
// Types and constants shared by the DMA channel register block.
// ============================================================================
`default_nettype none

package dcrb_pkg;

    // Command codes of a request word
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_START = 2'd2,
        CMD_DONE  = 2'd3
    } t_cmd;

    // Register selector of an access
    typedef enum logic [2:0] {
        REG_SRC  = 3'd0,
        REG_DST  = 3'd1,
        REG_CNT  = 3'd2,
        REG_CTL  = 3'd3,
        REG_GLOB = 3'd4
    } t_reg_kind;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_REG   = 3'd1,
        ST_BAD_SIZE  = 3'd2,
        ST_LEN_MISM  = 3'd3,
        ST_SRC_ALIGN = 3'd4,
        ST_DST_ALIGN = 3'd5
    } t_status;

    localparam int          MAX_SLOTS   = 3;  // channels 1..3 have storage
    localparam int          CH2_SLOT    = 1;  // storage slot of channel 2
    localparam int          TE_BIT      = 1;  // transfer-end flag in control
    localparam int          SIZE_LSB    = 4;  // transfer-size field, bits 6:4
    localparam logic [2:0]  SIZE_32BYTE = 3'd4;
    localparam int          UNIT_SHIFT  = 5;  // 32-byte units

    typedef struct packed {
        t_cmd        cmd;
        logic [1:0]  channel;
        logic [2:0]  reg_kind;
        logic [31:0] write_data;
        logic [31:0] dst_addr;
        logic [31:0] byte_count;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        t_status     status;
        logic        start_xfer;
        logic [31:0] xfer_src;
        logic [31:0] xfer_dst;
        logic [29:0] xfer_words;
        logic        done_pulse;
        logic        irq_pending;
    } t_rsp;

endpackage

`default_nettype wire

/* sv/dcrb_if.sv */
// ============================================================================
// dcrb_req_if / dcrb_rsp_if
// Valid/ready channels for request words and result words.
// ============================================================================
`default_nettype none

interface dcrb_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [1:0]  channel;
    logic [2:0]  reg_kind;
    logic [31:0] write_data;
    logic [31:0] dst_addr;
    logic [31:0] byte_count;

    modport source (output valid, cmd, channel, reg_kind, write_data, dst_addr,
                    byte_count, input ready);
    modport sink   (input valid, cmd, channel, reg_kind, write_data, dst_addr,
                    byte_count, output ready);
endinterface

interface dcrb_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [2:0]  status;
    logic        start_xfer;
    logic [31:0] xfer_src;
    logic [31:0] xfer_dst;
    logic [29:0] xfer_words;
    logic        done_pulse;
    logic        irq_pending;

    modport source (output valid, read_data, status, start_xfer, xfer_src,
                    xfer_dst, xfer_words, done_pulse, irq_pending, input ready);
    modport sink   (input valid, read_data, status, start_xfer, xfer_src,
                    xfer_dst, xfer_words, done_pulse, irq_pending, output ready);
endinterface

`default_nettype wire

/* sv/dcrb_core.sv */
// ============================================================================
// dcrb_core
// Channel register file, TE read-then-clear logic and channel-2 launch checks.
// ============================================================================
`default_nettype none

module dcrb_core #(
    parameter int NUM_SLOTS = 3
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire dcrb_pkg::t_req i_req,
    output dcrb_pkg::t_rsp      o_rsp
);

    localparam int IdxW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam bit HasCh2 = (NUM_SLOTS > dcrb_pkg::CH2_SLOT);

    logic [31:0] r_src [NUM_SLOTS];
    logic [31:0] r_dst [NUM_SLOTS];
    logic [31:0] r_cnt [NUM_SLOTS];
    logic [31:0] r_ctl [NUM_SLOTS];
    logic        r_ack [NUM_SLOTS];
    logic [31:0] r_gop;
    logic [31:0] r_pend;
    logic        r_busy;

    logic [31:0] n_src [NUM_SLOTS];
    logic [31:0] n_dst [NUM_SLOTS];
    logic [31:0] n_cnt [NUM_SLOTS];
    logic [31:0] n_ctl [NUM_SLOTS];
    logic        n_ack [NUM_SLOTS];
    logic [31:0] n_gop;
    logic [31:0] n_pend;
    logic        n_busy;

    always_comb begin
        logic            is_acc;
        logic            is_wr;
        logic            ch_ok;
        logic            acc_ok;
        logic            kind_glob;
        logic [IdxW-1:0] idx;
        logic [31:0]     c2_src;
        logic [31:0]     c2_cnt;
        logic [31:0]     c2_ctl;
        logic            len_ok;
        logic            launch;
        logic            apply;
        logic            sel;
        logic [31:0]     wval;
        logic [31:0]     rd;

        is_acc    = (i_req.cmd == dcrb_pkg::CMD_READ) || (i_req.cmd == dcrb_pkg::CMD_WRITE);
        is_wr     = (i_req.cmd == dcrb_pkg::CMD_WRITE);
        kind_glob = (i_req.reg_kind == dcrb_pkg::REG_GLOB);
        ch_ok     = (i_req.channel != 2'd0) && (int'(i_req.channel) <= NUM_SLOTS);
        acc_ok    = is_acc && ch_ok && (i_req.reg_kind < dcrb_pkg::REG_GLOB);
        idx       = IdxW'(i_req.channel - 2'd1);

        // channel-2 view
        c2_src = '0;
        c2_cnt = '0;
        c2_ctl = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (k == dcrb_pkg::CH2_SLOT) begin
                c2_src = r_src[k];
                c2_cnt = r_cnt[k];
                c2_ctl = r_ctl[k];
            end
        end

        // byte_count == 32 * count without wrap
        len_ok = (i_req.byte_count[dcrb_pkg::UNIT_SHIFT-1:0] == '0)
              && (c2_cnt[31:32-dcrb_pkg::UNIT_SHIFT] == '0)
              && (i_req.byte_count[31:dcrb_pkg::UNIT_SHIFT]
                  == c2_cnt[31-dcrb_pkg::UNIT_SHIFT:0]);

        o_rsp = '0;
        launch = 1'b0;
        apply  = 1'b0;

        if (is_acc) begin
            if (!kind_glob && !acc_ok) begin
                o_rsp.status = dcrb_pkg::ST_BAD_REG;
            end
        end else if (!HasCh2) begin
            o_rsp.status = dcrb_pkg::ST_BAD_REG;
        end else if (i_req.cmd == dcrb_pkg::CMD_START) begin
            priority if (c2_ctl[dcrb_pkg::SIZE_LSB +: 3] != dcrb_pkg::SIZE_32BYTE) begin
                o_rsp.status = dcrb_pkg::ST_BAD_SIZE;
            end else if (!len_ok) begin
                o_rsp.status = dcrb_pkg::ST_LEN_MISM;
            end else if (c2_src[dcrb_pkg::UNIT_SHIFT-1:0] != '0) begin
                o_rsp.status = dcrb_pkg::ST_SRC_ALIGN;
            end else if (i_req.dst_addr[dcrb_pkg::UNIT_SHIFT-1:0] != '0) begin
                o_rsp.status = dcrb_pkg::ST_DST_ALIGN;
            end else begin
                launch = 1'b1;
            end
        end else begin
            apply = r_busy;
        end

        // register reads
        rd = '0;
        if (is_acc && !is_wr && kind_glob) begin
            rd = r_gop;
        end
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (acc_ok && !is_wr && idx == IdxW'(k)) begin
                unique case (dcrb_pkg::t_reg_kind'(i_req.reg_kind))
                    dcrb_pkg::REG_SRC: rd = r_src[k];
                    dcrb_pkg::REG_DST: rd = r_dst[k];
                    dcrb_pkg::REG_CNT: rd = r_cnt[k];
                    dcrb_pkg::REG_CTL: rd = r_ctl[k];
                    default:           rd = '0;
                endcase
            end
        end

        // next state
        n_gop  = (is_wr && kind_glob) ? i_req.write_data : r_gop;
        n_pend = launch ? (c2_src + i_req.byte_count) : r_pend;
        n_busy = launch ? 1'b1 : (apply ? 1'b0 : r_busy);

        for (int k = 0; k < NUM_SLOTS; k++) begin
            n_src[k] = r_src[k];
            n_dst[k] = r_dst[k];
            n_cnt[k] = r_cnt[k];
            n_ctl[k] = r_ctl[k];
            n_ack[k] = r_ack[k];
            sel  = acc_ok && (idx == IdxW'(k));
            wval = i_req.write_data;
            if (sel && is_wr) begin
                unique case (dcrb_pkg::t_reg_kind'(i_req.reg_kind))
                    dcrb_pkg::REG_SRC: n_src[k] = i_req.write_data;
                    dcrb_pkg::REG_DST: n_dst[k] = i_req.write_data;
                    dcrb_pkg::REG_CNT: n_cnt[k] = i_req.write_data;
                    dcrb_pkg::REG_CTL: begin
                        // TE: software can never set it; clearing needs a prior read
                        if (wval[dcrb_pkg::TE_BIT]) begin
                            if (!r_ctl[k][dcrb_pkg::TE_BIT]) begin
                                wval[dcrb_pkg::TE_BIT] = 1'b0;
                            end
                        end else if (r_ctl[k][dcrb_pkg::TE_BIT]) begin
                            if (r_ack[k]) begin
                                n_ack[k] = 1'b0;
                            end else begin
                                wval[dcrb_pkg::TE_BIT] = 1'b1;
                            end
                        end
                        n_ctl[k] = wval;
                    end
                    default: ;
                endcase
            end
            if (sel && !is_wr && (i_req.reg_kind == dcrb_pkg::REG_CTL)
                && r_ctl[k][dcrb_pkg::TE_BIT]) begin
                n_ack[k] = 1'b1;
            end
            if (apply && k == dcrb_pkg::CH2_SLOT) begin
                n_cnt[k] = '0;
                n_src[k] = r_pend;
                n_ctl[k][dcrb_pkg::TE_BIT] = 1'b1;
                n_ack[k] = 1'b0;
            end
        end

        o_rsp.read_data  = rd;
        o_rsp.start_xfer = launch;
        o_rsp.xfer_src   = launch ? c2_src : '0;
        o_rsp.xfer_dst   = launch ? i_req.dst_addr : '0;
        o_rsp.xfer_words = launch ? i_req.byte_count[31:2] : '0;
        o_rsp.done_pulse = apply;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (k == dcrb_pkg::CH2_SLOT) begin
                o_rsp.irq_pending = n_ctl[k][dcrb_pkg::TE_BIT];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_src[k] <= '0;
                r_dst[k] <= '0;
                r_cnt[k] <= '0;
                r_ctl[k] <= '0;
                r_ack[k] <= 1'b0;
            end
            r_gop  <= '0;
            r_pend <= '0;
            r_busy <= 1'b0;
        end else if (i_fire) begin
            r_src  <= n_src;
            r_dst  <= n_dst;
            r_cnt  <= n_cnt;
            r_ctl  <= n_ctl;
            r_ack  <= n_ack;
            r_gop  <= n_gop;
            r_pend <= n_pend;
            r_busy <= n_busy;
        end
    end

endmodule

`default_nettype wire

/* sv/dma_channel_register_block_unit.sv */
// ============================================================================
// dma_channel_register_block_unit
// DMA channel register block: bus register access, channel-2 launch and
// completion handling, one result word per request word.
// ============================================================================
//
//  Channel   Dir  Modport  Word contents
//  --------  ---  -------  ---------------------------------------------------
//  i_req     in   sink     cmd, channel, reg_kind, write_data, dst_addr,
//                          byte_count
//  o_rsp     out  source   read_data, status, start_xfer, xfer_src, xfer_dst,
//                          xfer_words, done_pulse, irq_pending
//
//  One request word per cycle while i_req.ready is high; its result is captured
//  in the output register at the accept edge.
//  The register file updates at the accept edge, so back-to-back words see
//  each other's effects.
//  i_req.ready is low only while a result is held and o_rsp.ready is low.
//  Synchronous active-low reset clears all channel registers, busy and the
//  output valid.
// ============================================================================
`default_nettype none

module dma_channel_register_block_unit #(
    parameter int NUM_CHANNELS = 3
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dcrb_req_if.sink   i_req,
    dcrb_rsp_if.source o_rsp
);

    // storage for channels 1..min(NUM_CHANNELS, 3)
    localparam int NumSlots = (NUM_CHANNELS < dcrb_pkg::MAX_SLOTS) ?
                              NUM_CHANNELS : dcrb_pkg::MAX_SLOTS;

    dcrb_pkg::t_req req;
    dcrb_pkg::t_rsp n_rsp;
    dcrb_pkg::t_rsp r_rsp;
    logic           r_valid;
    logic           fire;

    // result register drains or is empty: take a new word
    assign i_req.ready = !r_valid || o_rsp.ready;
    assign fire        = i_req.valid && i_req.ready;

    assign req.cmd        = dcrb_pkg::t_cmd'(i_req.cmd);
    assign req.channel    = i_req.channel;
    assign req.reg_kind   = i_req.reg_kind;
    assign req.write_data = i_req.write_data;
    assign req.dst_addr   = i_req.dst_addr;
    assign req.byte_count = i_req.byte_count;

    dcrb_core #(
        .NUM_SLOTS (NumSlots)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (req),
        .o_rsp   (n_rsp)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (fire) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid       = r_valid;
    assign o_rsp.read_data   = r_rsp.read_data;
    assign o_rsp.status      = r_rsp.status;
    assign o_rsp.start_xfer  = r_rsp.start_xfer;
    assign o_rsp.xfer_src    = r_rsp.xfer_src;
    assign o_rsp.xfer_dst    = r_rsp.xfer_dst;
    assign o_rsp.xfer_words  = r_rsp.xfer_words;
    assign o_rsp.done_pulse  = r_rsp.done_pulse;
    assign o_rsp.irq_pending = r_rsp.irq_pending;

endmodule

`default_nettype wire
